### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the top-level rtl file of the jolt stencil block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");

`endif

### rtl/core/wpjs_pkg.sv
// ----------------------------------------------------------------------------
// wpjs_pkg
// types, constants and helper functions of the phase jolt stencil
// ----------------------------------------------------------------------------
package wpjs_pkg;

	// sizes of the store and the volume
	localparam int MAX_VOXELS   = 65536;
	localparam int ADDR_W       = $clog2(MAX_VOXELS);
	localparam int MAX_DIM      = 256;
	localparam int DIM_W        = 9;
	localparam int CRD_W        = 8;
	localparam int IDX_W        = 16;
	localparam int RAW_W        = 14;
	localparam int PH_W         = 15;
	localparam int OUT_W        = 17;
	localparam int CFG_AW       = 3;
	localparam int PXY_W        = 2 * DIM_W - 1;
	localparam int NVOX_W       = 3 * DIM_W - 2;

	// phase arithmetic
	localparam int PHASE_TURN   = 8192;
	localparam int INT13_OFFSET = 4096;
	localparam int DIFF_W       = 17;
	localparam int S1_W         = 16;
	localparam int S2_W         = 19;
	localparam int V1_W         = S1_W + 4;
	localparam int V2_W         = S2_W + 4;
	localparam int OUT_MAX      = 131071;

	// reciprocal constants, scaled by 2**RECIP_K and rounded up
	localparam int RECIP_K      = 25;
	localparam int RECIP_W      = 24;
	localparam logic [RECIP_W-1:0] RECIP_3 = 24'd11184811;
	localparam logic [RECIP_W-1:0] RECIP_6 = 24'd5592406;
	localparam logic [RECIP_W-1:0] RECIP_9 = 24'd3728271;

	// read sequence: three center gradients, then eighteen neighbor gradients
	localparam int N_FIRST      = 3;
	localparam int N_GRAD       = N_FIRST + 18;
	localparam int N_READS      = 2 * N_GRAD;
	localparam int RN_W         = $clog2(N_READS);
	localparam int GI_W         = RN_W - 1;
	localparam int CNT_W        = RN_W;

	// input kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_AW-1:0] {
		CFG_DIM_X  = 3'd0,
		CFG_DIM_Y  = 3'd1,
		CFG_DIM_Z  = 3'd2,
		CFG_INT13  = 3'd3,
		CFG_TWO_D  = 3'd4,
		CFG_JUMP   = 3'd5
	} cfg_idx_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic            load;
		logic            chk;
		logic            mem_we;
		logic            div_load;
		logic            div_step;
		logic            div_next;
		logic            coord_cap;
		logic            rd_issue;
		logic [RN_W-1:0] rd_num;
		logic            fin;
		logic            res_load;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic bad;
		logic is_read;
		logic out_busy;
	} sts_t;

	// decoded gradient slot
	typedef struct packed {
		logic       first;
		logic [1:0] c;
		logic [1:0] a;
		logic       lopos;
	} gsel_t;

	// gradient slot to component, offset axis and offset sign
	function automatic gsel_t gdec(input logic [GI_W-1:0] gi);
		gsel_t      g;
		logic [4:0] k;
		logic [3:0] pr;
		g  = '0;
		k  = 5'(gi) - 5'(N_FIRST);
		pr = k[4:1];
		if (gi < GI_W'(N_FIRST)) begin
			g.first = 1'b1;
			g.c     = gi[1:0];
		end else begin
			g.lopos = k[0];
			g.c     = (pr >= 4'd6) ? 2'd2 : (pr >= 4'd3) ? 2'd1 : 2'd0;
			g.a     = 2'(pr - 4'(3 * g.c));
		end
		return g;
	endfunction

	function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	// pick d, d + turn or d - turn by strictly smaller magnitude
	function automatic logic signed [DIFF_W-1:0] wrap_diff(input logic signed [DIFF_W-1:0] d1);
		logic signed [DIFF_W-1:0] d2;
		logic signed [DIFF_W-1:0] d3;
		logic signed [DIFF_W-1:0] r;
		d2 = d1 + DIFF_W'(PHASE_TURN);
		d3 = d1 - DIFF_W'(PHASE_TURN);
		if (mag(d2) < mag(d1))
			r = d2;
		else if (mag(d3) < mag(d1))
			r = d3;
		else
			r = d1;
		return r;
	endfunction

	// zero acts as one, oversize acts as the largest dimension
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage

### rtl/core/wrapped_phase_jolt_stencil_unit.sv
// ----------------------------------------------------------------------------
// wrapped_phase_jolt_stencil_unit
// wrapped phase volume store with jump and jolt stencil readout
// ----------------------------------------------------------------------------
// usage
// - slave stream: tuser is the kind (write or read), tdata holds the voxel
//   index and the raw phase; every accepted transaction gives one result
// - master stream: tdata holds jolt and jump, tuser flags an index beyond
//   the configured volume
// - config port: cfg_we writes cfg_data to register cfg_addr; the user must
//   write only while idle, which the block itself does not enforce
// - sequence: a write or a bad index offers its result after a range check;
//   a read runs a range check, two divides for the coordinates, 42 reads of
//   the single-port phase ram for 21 gradients, a drain and a reciprocal multiply
// - one transaction at a time: the next transaction is accepted once the
//   result sits in the output register
// - reset clears the configuration to a 1x1x1 volume and empties the output;
//   phase ram content is undefined until written
// - a stalled receiver holds the result; work stops before loading the next
//   result until the register frees
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrapped_phase_jolt_stencil_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // voxel_index[15:0], phase_raw[29:16]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // jolt[16:0], jump[33:17]
	output logic        m_tuser    // bad_index
);
	import wpjs_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [OUT_W-1:0] jolt, jump;

	// controller
	wpjs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	wpjs_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_kind  (s_tuser),
		.in_index (s_tdata[IDX_W-1:0]),
		.in_raw   (s_tdata[IDX_W+RAW_W-1:IDX_W]),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_jolt (jolt),
		.out_jump (jump),
		.out_bad  (m_tuser)
	);

	assign m_tdata = {6'b0, jump, jolt};

	// one transaction in flight at a time
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a waiting result is never overwritten
	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.res_load, !(m_tvalid && !m_tready))
	// the single ram port is not shared in one cycle
	`ASSERT_IMPLIES(a_port_excl, clk, arst_n, cmd.mem_we, !cmd.rd_issue)

endmodule

### rtl/core/wpjs_ram.sv
// ----------------------------------------------------------------------------
// wpjs_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module wpjs_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

### rtl/core/wpjs_ctrl.sv
// ----------------------------------------------------------------------------
// wpjs_ctrl
// sequencer for one transaction: check, then a store write or coordinate divides and stencil reads
// ----------------------------------------------------------------------------
module wpjs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  wpjs_pkg::sts_t sts,
	output wpjs_pkg::cmd_t cmd
);
	import wpjs_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_PREP  = 11'b000_0000_0010,
		ST_CHECK = 11'b000_0000_0100,
		ST_DIVX  = 11'b000_0000_1000,
		ST_DNEXT = 11'b000_0001_0000,
		ST_DIVY  = 11'b000_0010_0000,
		ST_COORD = 11'b000_0100_0000,
		ST_READ  = 11'b000_1000_0000,
		ST_DRAIN = 11'b001_0000_0000,
		ST_FIN   = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_CHECK;
			ST_CHECK: begin
				cmd.chk = 1'b1;
				cnt_d   = '0;
				if (sts.bad || !sts.is_read) begin
					cmd.mem_we = !sts.bad && !sts.is_read;
					state_d    = ST_DONE;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIVX;
				end
			end
			ST_DIVX: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(IDX_W - 1)) begin
					cnt_d   = '0;
					state_d = ST_DNEXT;
				end
			end
			ST_DNEXT: begin
				cmd.div_next = 1'b1;
				state_d      = ST_DIVY;
			end
			ST_DIVY: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(IDX_W - 1)) begin
					cnt_d   = '0;
					state_d = ST_COORD;
				end
			end
			ST_COORD: begin
				cmd.coord_cap = 1'b1;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_num   = cnt_q;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N_READS - 1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(2)) begin
					cnt_d   = '0;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### rtl/core/wpjs_dpath.sv
// ----------------------------------------------------------------------------
// wpjs_dpath
// config registers, phase store, coordinate divider, gradient pipeline, output
// ----------------------------------------------------------------------------
module wpjs_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wpjs_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [wpjs_pkg::DIM_W-1:0]  cfg_data,
	input  logic                        in_kind,
	input  logic [wpjs_pkg::IDX_W-1:0]  in_index,
	input  logic [wpjs_pkg::RAW_W-1:0]  in_raw,
	input  wpjs_pkg::cmd_t              cmd,
	output wpjs_pkg::sts_t              sts,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wpjs_pkg::OUT_W-1:0]  out_jolt,
	output logic [wpjs_pkg::OUT_W-1:0]  out_jump,
	output logic                        out_bad
);
	import wpjs_pkg::*;

	// configuration
	logic [DIM_W-1:0]  dim_x_q, dim_y_q, dim_z_q;
	logic              int13_q, two_d_q, jump_en_q;
	logic [DIM_W-1:0]  ex, ey, ez;
	logic [PXY_W-1:0]  pxy_q;
	logic [NVOX_W-1:0] nvox_q;

	// item
	logic              kind_q, bad_q;
	logic [IDX_W-1:0]  idx_q;
	logic [RAW_W-1:0]  raw_q;

	// divider and coordinates
	logic [IDX_W-1:0]  num_q;
	logic [CRD_W-1:0]  rem_q;
	logic              divy_q;
	logic [DIM_W-1:0]  div_d, trial;
	logic              ge;
	logic [CRD_W-1:0]  x_q, y_q;
	logic [IDX_W-1:0]  z_q;

	// store
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr, rd_addr;
	logic [PH_W-1:0]   mem_wdata, rdata;

	// gradient pipeline
	gsel_t                    gs0, gs1, gs2;
	logic [RN_W-1:0]          r_s1;
	logic                     v_s1, v_s2, v_s3;
	logic [GI_W-1:0]          gi_s2;
	logic [PH_W-1:0]          hi_q;
	logic signed [DIFF_W-1:0] g_s2, ghi_q, gval, tval;
	logic                     g_ok, t_ok;
	logic [DIFF_W-1:0]        term_s3;
	logic [S1_W-1:0]          s1sum_q;
	logic [S2_W-1:0]          s2sum_q;

	// final scaling
	logic [V2_W+RECIP_W-1:0]  jolt_prod_q;
	logic [V1_W+RECIP_W-1:0]  jump_prod_q;
	logic [V2_W+RECIP_W-RECIP_K-1:0] jolt_q;
	logic [V1_W+RECIP_W-RECIP_K-1:0] jump3;
	logic [S1_W+2:0]          jump2;
	logic [S1_W+2:0]          jump_pre;
	logic [OUT_W-1:0]         jolt_sat, jump_sat;
	logic                     good_read;
	logic                     m_valid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q   <= DIM_W'(1);
			dim_y_q   <= DIM_W'(1);
			dim_z_q   <= DIM_W'(1);
			int13_q   <= 1'b0;
			two_d_q   <= 1'b0;
			jump_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DIM_X: dim_x_q   <= cfg_data;
				CFG_DIM_Y: dim_y_q   <= cfg_data;
				CFG_DIM_Z: dim_z_q   <= cfg_data;
				CFG_INT13: int13_q   <= cfg_data[0];
				CFG_TWO_D: two_d_q   <= cfg_data[0];
				CFG_JUMP:  jump_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ex = eff_dim(dim_x_q);
	assign ey = eff_dim(dim_y_q);
	assign ez = eff_dim(dim_z_q);

	// plane size and volume, one multiply per stage
	always_ff @(posedge clk) begin
		pxy_q  <= PXY_W'(ex * ey);
		nvox_q <= NVOX_W'(pxy_q * ez);
	end

	// item capture and range check
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			idx_q  <= in_index;
			raw_q  <= in_raw;
		end
		if (cmd.chk)
			bad_q <= sts.bad;
	end

	assign sts.bad     = NVOX_W'(idx_q) >= nvox_q;
	assign sts.is_read = (kind_q == KIND_READ);

	// restoring divider, one quotient bit per cycle
	assign div_d = divy_q ? ey : ex;
	assign trial = {rem_q, num_q[IDX_W-1]};
	assign ge    = trial >= div_d;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q  <= idx_q;
			rem_q  <= '0;
			divy_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[IDX_W-2:0], ge};
			rem_q <= ge ? CRD_W'(trial - div_d) : CRD_W'(trial);
		end else if (cmd.div_next) begin
			x_q    <= rem_q;
			rem_q  <= '0;
			divy_q <= 1'b1;
		end
		if (cmd.coord_cap) begin
			y_q <= rem_q;
			z_q <= num_q;
		end
	end

	// stencil read address: center plus neighbor offset plus component offset
	function automatic logic [ADDR_W-1:0] stride(input logic [1:0] ax, input logic [DIM_W-1:0] sx,
		input logic [PXY_W-1:0] sxy);
		logic [ADDR_W-1:0] r;
		case (ax)
			2'd0:    r = ADDR_W'(1);
			2'd1:    r = ADDR_W'(sx);
			default: r = sxy[ADDR_W-1:0];
		endcase
		return r;
	endfunction

	always_comb begin
		logic [ADDR_W-1:0] sa, sc, oa, oc;
		gs0 = gdec(cmd.rd_num[RN_W-1:1]);
		sa  = stride(gs0.a, ex, pxy_q);
		sc  = stride(gs0.c, ex, pxy_q);
		oa  = gs0.first ? '0 : (gs0.lopos ? ADDR_W'(-sa) : sa);
		oc  = cmd.rd_num[0] ? ADDR_W'(-sc) : sc;
		rd_addr = idx_q + oa + oc;
	end

	assign mem_we    = cmd.mem_we;
	assign mem_addr  = mem_we ? idx_q : rd_addr;
	assign mem_wdata = PH_W'($signed(raw_q)) + (int13_q ? PH_W'(INT13_OFFSET) : PH_W'(0));

	wpjs_ram #(
		.WIDTH (PH_W),
		.DEPTH (MAX_VOXELS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	// coordinate and size along one axis
	function automatic logic [IDX_W:0] coord(input logic [1:0] ax, input logic [CRD_W-1:0] cx,
		input logic [CRD_W-1:0] cy, input logic [IDX_W-1:0] cz);
		logic [IDX_W:0] r;
		case (ax)
			2'd0:    r = (IDX_W+1)'(cx);
			2'd1:    r = (IDX_W+1)'(cy);
			default: r = (IDX_W+1)'(cz);
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W:0] dimof(input logic [1:0] ax, input logic [DIM_W-1:0] dx,
		input logic [DIM_W-1:0] dy, input logic [DIM_W-1:0] dz);
		logic [IDX_W:0] r;
		case (ax)
			2'd0:    r = (IDX_W+1)'(dx);
			2'd1:    r = (IDX_W+1)'(dy);
			default: r = (IDX_W+1)'(dz);
		endcase
		return r;
	endfunction

	// first gradient: valid when its position is inside along the component
	always_comb begin
		logic [IDX_W:0] base;
		gs1  = gdec(r_s1[RN_W-1:1]);
		base = coord(gs1.c, x_q, y_q, z_q);
		if (!gs1.first && gs1.a == gs1.c)
			base = gs1.lopos ? base - 1'b1 : base + 1'b1;
		g_ok = (base != '0) && (base + 1'b1 < dimof(gs1.c, ex, ey, ez)) &&
			!(two_d_q && gs1.c == 2'd2);
		gval = wrap_diff(DIFF_W'($signed(hi_q)) - DIFF_W'($signed(rdata)));
	end

	// second gradient: valid when the center is inside along the offset axis
	always_comb begin
		logic [IDX_W:0] pc;
		gs2  = gdec(gi_s2);
		pc   = coord(gs2.a, x_q, y_q, z_q);
		t_ok = (pc != '0) && (pc + 1'b1 < dimof(gs2.a, ex, ey, ez)) &&
			!(two_d_q && gs2.c == 2'd2);
		tval = wrap_diff(ghi_q - g_s2);
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_issue;
			v_s2 <= v_s1 && r_s1[0];
			v_s3 <= v_s2 && !gs2.first && gs2.lopos;
		end
	end

	// gradient pipeline and sums
	always_ff @(posedge clk) begin
		r_s1 <= cmd.rd_num;
		if (v_s1 && !r_s1[0])
			hi_q <= rdata;
		g_s2  <= g_ok ? gval : '0;
		gi_s2 <= r_s1[RN_W-1:1];
		if (v_s2 && !gs2.first && !gs2.lopos)
			ghi_q <= g_s2;
		term_s3 <= t_ok ? mag(tval) : '0;
		if (cmd.chk) begin
			s1sum_q <= '0;
			s2sum_q <= '0;
		end else begin
			if (v_s2 && gs2.first)
				s1sum_q <= s1sum_q + S1_W'(mag(g_s2));
			if (v_s3)
				s2sum_q <= s2sum_q + S2_W'(term_s3);
		end
	end

	// divide by the term count through reciprocal multiplies
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			jolt_prod_q <= {s2sum_q, 4'b0} * (two_d_q ? RECIP_6 : RECIP_9);
			jump_prod_q <= {s1sum_q, 4'b0} * RECIP_3;
		end
	end

	assign jolt_q    = jolt_prod_q[V2_W+RECIP_W-1:RECIP_K];
	assign jump3     = jump_prod_q[V1_W+RECIP_W-1:RECIP_K];
	assign jump2     = {s1sum_q, 3'b0};
	assign jump_pre  = two_d_q ? jump2 : (S1_W+3)'(jump3);
	assign jolt_sat  = (jolt_q > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(jolt_q);
	assign jump_sat  = (jump_pre > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(jump_pre);
	assign good_read = (kind_q == KIND_READ) && !bad_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (cmd.res_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_jolt <= good_read ? jolt_sat : '0;
			out_jump <= (good_read && jump_en_q) ? jump_sat : '0;
			out_bad  <= bad_q;
		end
	end

	assign m_tvalid     = m_valid_q;
	assign sts.out_busy = m_valid_q && !m_tready;

endmodule

### tb/tb_wrapped_phase_jolt_stencil_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wrapped_phase_jolt_stencil_unit
// self-checking bench for the wrapped phase jolt stencil unit
// ----------------------------------------------------------------------------
// every accepted input transaction updates a local copy of the phase volume
// and predicts the jolt, jump and bad-index result; results are checked in
// order. each volume is fully written before it is read, so every stencil
// term that counts comes from a written store entry.
// ----------------------------------------------------------------------------
module tb_wrapped_phase_jolt_stencil_unit;
	import wpjs_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [16:0] jolt;
		logic [16:0] jump;
		logic        bad;
	} stencil_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [8:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // voxel_index[15:0], phase_raw[29:16]
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // jolt[16:0], jump[33:17]
	logic        m_tuser;   // bad_index

	// local copy of configuration and phase store
	logic [8:0]         dim_reg [3];
	logic               int13_on, two_d_on, jump_on;
	logic signed [14:0] phase_mem [0:MAX_VOXELS-1];
	int                 edim [3];

	stencil_result_t pending_results [$];
	int  mismatches;
	int  send_idle_pct, recv_idle_pct;
	int  hold_cycles;
	int  quiet_cycles;

	wrapped_phase_jolt_stencil_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int clamp_dim(input logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic int abs_i(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// shortest of d, d + turn, d - turn, in that order of preference
	function automatic int wrapped_delta(input int hi, input int lo);
		int d1, d2, d3;
		d1 = hi - lo;
		d2 = d1 + PHASE_TURN;
		d3 = d1 - PHASE_TURN;
		if (abs_i(d2) < abs_i(d1))
			return d2;
		if (abs_i(d3) < abs_i(d1))
			return d3;
		return d1;
	endfunction

	function automatic bit on_inside(input int px, input int py, input int pz, input int ax);
		int c;
		c = (ax == 0) ? px : (ax == 1) ? py : pz;
		return c > 0 && c + 1 < edim[ax];
	endfunction

	function automatic int phase_at(input int px, input int py, input int pz);
		longint a;
		a = longint'(px) + longint'(edim[0]) * (longint'(py) + longint'(edim[1]) * pz);
		return int'(phase_mem[a % MAX_VOXELS]);
	endfunction

	function automatic int phase_grad(input int px, input int py, input int pz, input int ax);
		int dx, dy, dz;
		if (!on_inside(px, py, pz, ax))
			return 0;
		if (ax == 2 && two_d_on)
			return 0;
		dx = (ax == 0);
		dy = (ax == 1);
		dz = (ax == 2);
		return wrapped_delta(phase_at(px + dx, py + dy, pz + dz),
			phase_at(px - dx, py - dy, pz - dz));
	endfunction

	function automatic int grad_delta(input int px, input int py, input int pz,
			input int comp, input int ax);
		int dx, dy, dz;
		if (!on_inside(px, py, pz, ax))
			return 0;
		dx = (ax == 0);
		dy = (ax == 1);
		dz = (ax == 2);
		return wrapped_delta(phase_grad(px + dx, py + dy, pz + dz, comp),
			phase_grad(px - dx, py - dy, pz - dz, comp));
	endfunction

	function automatic logic [16:0] saturate(input longint v);
		return (v > OUT_MAX) ? 17'(OUT_MAX) : 17'(v);
	endfunction

	// apply one transaction to the local volume and return its result
	function automatic stencil_result_t stencil_predict(input logic kind,
			input logic [15:0] idx, input logic signed [13:0] raw);
		stencil_result_t r;
		longint nvox, s1, s2;
		int px, py, pz, ncomp;
		for (int i = 0; i < 3; i++)
			edim[i] = clamp_dim(dim_reg[i]);
		nvox = longint'(edim[0]) * edim[1] * edim[2];
		r.jolt = '0;
		r.jump = '0;
		r.bad = (longint'(idx) >= nvox);
		if (r.bad)
			return r;
		if (kind == KIND_WRITE) begin
			phase_mem[idx] = 15'(int'(raw) + (int13_on ? INT13_OFFSET : 0));
			return r;
		end
		px = int'(idx) % edim[0];
		py = (int'(idx) / edim[0]) % edim[1];
		pz = int'(idx) / (edim[0] * edim[1]);
		ncomp = two_d_on ? 2 : 3;
		s1 = 0;
		s2 = 0;
		for (int a = 0; a < 3; a++)
			s1 += abs_i(phase_grad(px, py, pz, a));
		for (int c = 0; c < ncomp; c++)
			for (int a = 0; a < 3; a++)
				s2 += abs_i(grad_delta(px, py, pz, c, a));
		r.jolt = saturate(s2 * 16 / (ncomp * 3));
		if (jump_on)
			r.jump = saturate(s1 * 16 / (two_d_on ? 2 : 3));
		return r;
	endfunction

	// ---------------------------------------------------------------- receiver and checker

	always @(posedge clk) begin
		stencil_result_t exp_r;
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction jolt=%0d jump=%0d bad=%0b",
					$time, m_tdata[16:0], m_tdata[33:17], m_tuser);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[16:0] !== exp_r.jolt) begin
					$display("%0t: jolt expected %0d actual %0d", $time, exp_r.jolt, m_tdata[16:0]);
					mismatches++;
				end
				if (m_tdata[33:17] !== exp_r.jump) begin
					$display("%0t: jump expected %0d actual %0d", $time, exp_r.jump, m_tdata[33:17]);
					mismatches++;
				end
				if (m_tuser !== exp_r.bad) begin
					$display("%0t: bad_index expected %0b actual %0b", $time, exp_r.bad, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("** wrapped_phase_jolt_stencil_unit: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- shared tasks

	// offer one item, wait for its transaction, maybe idle afterwards
	task automatic send_item(input logic kind, input int idx, input int raw);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, 14'(raw), 16'(idx)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(stencil_predict(kind, 16'(idx), 14'(raw)));
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [8:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIM_X: dim_reg[0] = value;
			CFG_DIM_Y: dim_reg[1] = value;
			CFG_DIM_Z: dim_reg[2] = value;
			CFG_INT13: int13_on = value[0];
			CFG_TWO_D: two_d_on = value[0];
			CFG_JUMP:  jump_on = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_volume(input int dx, input int dy, input int dz,
			input bit i13, input bit twod, input bit jmp);
		wait_idle();
		write_reg(CFG_DIM_X, 9'(dx));
		write_reg(CFG_DIM_Y, 9'(dy));
		write_reg(CFG_DIM_Z, 9'(dz));
		write_reg(CFG_INT13, 9'(i13));
		write_reg(CFG_TWO_D, 9'(twod));
		write_reg(CFG_JUMP, 9'(jmp));
	endtask

	function automatic int volume_size();
		return clamp_dim(dim_reg[0]) * clamp_dim(dim_reg[1]) * clamp_dim(dim_reg[2]);
	endfunction

	function automatic int rand_phase();
		return int'($urandom_range(16383)) - 8192;
	endfunction

	// write every voxel so that reads only touch written entries
	task automatic fill_volume();
		int n;
		n = volume_size();
		for (int i = 0; i < n; i++)
			send_item(KIND_WRITE, i, rand_phase());
	endtask

	// mostly reads of written voxels, some writes, some indexes out of range
	task automatic random_traffic(input int count);
		int n, sel;
		n = volume_size();
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 60)
				send_item(KIND_READ, $urandom_range(n - 1), rand_phase());
			else if (sel < 85)
				send_item(KIND_WRITE, $urandom_range(n - 1), rand_phase());
			else
				send_item(1'($urandom_range(1)), $urandom_range(65535, n), rand_phase());
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// reset volume is one voxel: read of a boundary voxel and an index beyond it
		send_item(KIND_WRITE, 0, 8191);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, 65535, -8192);
		// 3x3x3 with extreme phases, checker pattern forces wrapping
		set_volume(3, 3, 3, 0, 0, 1);
		for (int i = 0; i < 27; i++)
			send_item(KIND_WRITE, i, (i % 2) ? 8191 : -8192);
		send_item(KIND_READ, 13, 0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, 26, 0);
		send_item(KIND_WRITE, 27, 100);
		send_item(KIND_READ, 27, 0);
		// int13 offset on two neighbors, with jump disabled
		set_volume(3, 3, 3, 1, 0, 0);
		send_item(KIND_WRITE, 14, 4096);
		send_item(KIND_WRITE, 12, -4096);
		send_item(KIND_READ, 13, 0);
		// same stored data seen in 2d mode
		set_volume(3, 3, 3, 1, 1, 1);
		send_item(KIND_READ, 13, 0);
	endtask

	task automatic test_volumes();
		// dimension zero acts as one, oversize acts as the largest
		set_volume(0, 0, 0, 0, 0, 1);
		fill_volume();
		random_traffic(10);
		set_volume(511, 1, 1, 1, 0, 1);
		fill_volume();
		random_traffic(30);
		set_volume(1, 64, 1, 0, 1, 1);
		fill_volume();
		random_traffic(20);
		set_volume(2, 2, 2, 0, 0, 1);
		fill_volume();
		random_traffic(20);
	endtask

	task automatic test_random(input int s_pct, input int r_pct, input bit twod);
		set_volume(4 + $urandom_range(2), 3 + $urandom_range(2), 3 + $urandom_range(2),
			1'($urandom_range(1)), twod, 1'($urandom_range(1)));
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		fill_volume();
		random_traffic(100);
	endtask

	// receiver stalls for a long stretch while items keep coming
	task automatic test_backpressure();
		set_volume(3, 3, 3, 0, 0, 1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 600;
		fill_volume();
		random_traffic(20);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		dim_reg[0] = 9'd1;
		dim_reg[1] = 9'd1;
		dim_reg[2] = 9'd1;
		int13_on = 1'b0;
		two_d_on = 1'b0;
		jump_on = 1'b0;
		for (int i = 0; i < MAX_VOXELS; i++)
			phase_mem[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_volumes();
		test_random(18, 51, 0);
		test_random(51, 18, 1);
		test_random(0, 0, 0);
		test_backpressure();

		wait_idle();
		if (mismatches == 0)
			$display("** wrapped_phase_jolt_stencil_unit: PASSED **");
		else
			$display("** wrapped_phase_jolt_stencil_unit: FAILED **");
		$finish;
	end

endmodule
